// File: hw/rtl/ltsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ltsm_pkg;

    localparam int ADDR_BITS_DEF = 64;

    // divider: 68-bit dividend (65-bit sum padded), 4 quotient bits per cycle
    localparam int DIV_W     = 68;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYC   = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

    localparam logic [7:0] CONST_ADD_TOP  = 8'd255;
    localparam logic [7:0] SET_ADDR_LEN64 = 8'd9;
    localparam logic [7:0] SET_ADDR_LEN32 = 8'd5;

    localparam logic [2:0] ST_ROW      = 3'd0;
    localparam logic [2:0] ST_BAD_STD  = 3'd1;
    localparam logic [2:0] ST_BAD_EXT  = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_DEF_FILE = 3'd4;

    localparam logic [7:0] EXT_END_SEQ  = 8'd1;
    localparam logic [7:0] EXT_SET_ADDR = 8'd2;
    localparam logic [7:0] EXT_DEF_FILE = 8'd3;
    localparam logic [7:0] EXT_SET_DISC = 8'd4;

    localparam logic [7:0] OP_EXTENDED  = 8'd0;
    localparam logic [7:0] OP_COPY      = 8'd1;
    localparam logic [7:0] OP_ADV_PC    = 8'd2;
    localparam logic [7:0] OP_ADV_LINE  = 8'd3;
    localparam logic [7:0] OP_SET_FILE  = 8'd4;
    localparam logic [7:0] OP_SET_COL   = 8'd5;
    localparam logic [7:0] OP_NEG_STMT  = 8'd6;
    localparam logic [7:0] OP_SET_BB    = 8'd7;
    localparam logic [7:0] OP_CONST_ADD = 8'd8;
    localparam logic [7:0] OP_FIXED_ADV = 8'd9;
    localparam logic [7:0] OP_PRO_END   = 8'd10;
    localparam logic [7:0] OP_EPI_BEGIN = 8'd11;
    localparam logic [7:0] OP_SET_ISA   = 8'd12;

    localparam logic [2:0] CFG_MIN_LEN  = 3'd0;
    localparam logic [2:0] CFG_MAX_OPS  = 3'd1;
    localparam logic [2:0] CFG_DEF_STMT = 3'd2;
    localparam logic [2:0] CFG_LINE_BASE = 3'd3;
    localparam logic [2:0] CFG_LINE_RNG = 3'd4;
    localparam logic [2:0] CFG_FIRST_SP = 3'd5;

    typedef enum logic [4:0] {
        K_END_SEQ,
        K_SET_ADDR,
        K_SET_DISC,
        K_ERROR,
        K_COPY,
        K_ADV_PC,
        K_ADV_LINE,
        K_SET_FILE,
        K_SET_COL,
        K_NEG_STMT,
        K_SET_BB,
        K_CONST_ADD,
        K_FIXED_ADV,
        K_PRO_END,
        K_EPI_BEGIN,
        K_SET_ISA,
        K_SPECIAL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  status;
        logic [7:0]  adj;
        logic [63:0] val_u;
        logic [63:0] val_s;
    } t_cmd;

    typedef struct packed {
        logic [7:0] min_len;
        logic [7:0] max_ops;
        logic       def_stmt;
        logic [7:0] ln_base;
        logic [7:0] line_rng;
        logic [7:0] first_sp;
    } t_cfg;

endpackage
`default_nettype wire

// File: hw/rtl/ltsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ltsm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ltsm_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [7:0]          i_opcode,
    input  wire  [7:0]          i_ext_opcode,
    input  wire  [7:0]          i_ext_length,
    input  wire  [63:0]         i_operand_u,
    input  wire  [63:0]         i_operand_s,
    input  wire                 i_pop,
    output logic                o_empty,
    output ltsm_pkg::t_cmd      o_cmd
);
    import ltsm_pkg::*;

    t_cmd       w_cmd;
    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd        = '0;
        w_cmd.kind   = K_ERROR;
        w_cmd.val_u  = i_operand_u;
        w_cmd.val_s  = i_operand_s;
        w_cmd.status = ST_ROW;
        if (i_opcode == OP_EXTENDED) begin
            unique case (i_ext_opcode)
                EXT_END_SEQ: w_cmd.kind = K_END_SEQ;
                EXT_SET_ADDR: begin
                    if (i_ext_length == SET_ADDR_LEN64) begin
                        w_cmd.kind = K_SET_ADDR;
                    end else if (i_ext_length == SET_ADDR_LEN32) begin
                        w_cmd.kind  = K_SET_ADDR;
                        w_cmd.val_u = {32'd0, i_operand_u[31:0]};
                    end else begin
                        w_cmd.status = ST_BAD_ADDR;
                    end
                end
                EXT_DEF_FILE: w_cmd.status = ST_DEF_FILE;
                EXT_SET_DISC: w_cmd.kind   = K_SET_DISC;
                default:      w_cmd.status = ST_BAD_EXT;
            endcase
        end else if (i_opcode < i_cfg.first_sp) begin
            unique case (i_opcode)
                OP_COPY:      w_cmd.kind = K_COPY;
                OP_ADV_PC:    w_cmd.kind = K_ADV_PC;
                OP_ADV_LINE:  w_cmd.kind = K_ADV_LINE;
                OP_SET_FILE:  w_cmd.kind = K_SET_FILE;
                OP_SET_COL:   w_cmd.kind = K_SET_COL;
                OP_NEG_STMT:  w_cmd.kind = K_NEG_STMT;
                OP_SET_BB:    w_cmd.kind = K_SET_BB;
                OP_CONST_ADD: begin
                    w_cmd.kind = K_CONST_ADD;
                    w_cmd.adj  = CONST_ADD_TOP - i_cfg.first_sp;
                end
                OP_FIXED_ADV: w_cmd.kind = K_FIXED_ADV;
                OP_PRO_END:   w_cmd.kind = K_PRO_END;
                OP_EPI_BEGIN: w_cmd.kind = K_EPI_BEGIN;
                OP_SET_ISA:   w_cmd.kind = K_SET_ISA;
                default:      w_cmd.status = ST_BAD_STD;
            endcase
        end else begin
            w_cmd.kind = K_SPECIAL;
            w_cmd.adj  = i_opcode - i_cfg.first_sp;
        end
    end

    assign o_stall = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ltsm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ltsm_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [ltsm_pkg::DIV_W-1:0] i_dividend,
    input  wire  [7:0]                 i_divisor,
    output logic                       o_done,
    output logic [ltsm_pkg::DIV_W-1:0] o_quotient,
    output logic [7:0]                 o_remainder
);
    import ltsm_pkg::*;

    // restoring division, dividend shifts out the top while quotient shifts in
    logic [DIV_W-1:0]     r_work;
    logic [DIV_W-1:0]     n_work;
    logic [7:0]           r_rem;
    logic [7:0]           n_rem;
    logic [7:0]           r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_comb begin
        logic [8:0] t;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t      = {n_rem, n_work[DIV_W-1]};
            n_work = {n_work[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t         = t - {1'b0, r_div};
                n_work[0] = 1'b1;
            end
            n_rem = t[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= 8'd0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// File: hw/rtl/ltsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ltsm_back #(
    parameter int ADDRESS_BITS = ltsm_pkg::ADDR_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ltsm_pkg::t_cfg      i_cfg,
    input  wire                 i_empty,
    input  ltsm_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [2:0]          o_status,
    output logic [63:0]         o_row_address,
    output logic [7:0]          o_row_op_idx,
    output logic [63:0]         o_row_file,
    output logic [63:0]         o_row_line,
    output logic [63:0]         o_row_column,
    output logic [4:0]          o_row_flags,
    output logic [63:0]         o_row_isa,
    output logic [63:0]         o_row_discriminator
);
    import ltsm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV_ADJ = 6'b000010,
        S_DIV_OPS = 6'b000100,
        S_MUL     = 6'b001000,
        S_ADD     = 6'b010000,
        S_EMIT    = 6'b100000
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [ADDRESS_BITS-1:0] r_address;
    logic [7:0]              r_op_idx;
    logic [63:0]             r_file;
    logic [63:0]             r_line;
    logic [63:0]             r_column;
    logic                    r_is_stmt;
    logic                    r_bb;
    logic                    r_pro;
    logic                    r_epi;
    logic [63:0]             r_isa;
    logic [63:0]             r_disc;
    logic [7:0]              r_delta;
    logic [ADDRESS_BITS-1:0] r_prod;
    logic                    r_out_valid;

    logic [7:0]              w_m;
    logic [7:0]              w_rng;
    logic                    w_div_start;
    logic [DIV_W-1:0]        w_dividend;
    logic [7:0]              w_divisor;
    logic                    w_div_done;
    logic [DIV_W-1:0]        w_quo;
    logic [7:0]              w_rem;
    logic                    w_out_free;
    logic                    w_has_res;

    assign w_m   = (i_cfg.max_ops == 8'd0) ? 8'd1 : i_cfg.max_ops;
    assign w_rng = (i_cfg.line_rng == 8'd0) ? 8'd1 : i_cfg.line_rng;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_has_res  = (r_cmd.kind == K_END_SEQ) || (r_cmd.kind == K_ERROR) ||
                        (r_cmd.kind == K_COPY) || (r_cmd.kind == K_SPECIAL);

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = w_m;
        if (o_pop) begin
            if (i_cmd.kind == K_SPECIAL || i_cmd.kind == K_CONST_ADD) begin
                w_div_start = 1'b1;
                w_dividend  = DIV_W'(i_cmd.adj);
                w_divisor   = w_rng;
            end else if (i_cmd.kind == K_ADV_PC) begin
                w_div_start = 1'b1;
                w_dividend  = DIV_W'(i_cmd.val_u) + DIV_W'(r_op_idx);
            end
        end else if (r_state == S_DIV_ADJ && w_div_done) begin
            // adj / range advances ops; its sum with the op index is one exact divide
            w_div_start = 1'b1;
            w_dividend  = DIV_W'(w_quo[7:0]) + DIV_W'(r_op_idx);
        end
    end

    ltsm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_address   <= '0;
            r_op_idx    <= 8'd0;
            r_file      <= 64'd1;
            r_line      <= 64'd1;
            r_column    <= 64'd0;
            r_is_stmt   <= 1'b1;
            r_bb        <= 1'b0;
            r_pro       <= 1'b0;
            r_epi       <= 1'b0;
            r_isa       <= 64'd0;
            r_disc      <= 64'd0;
        end else begin
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= w_has_res;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.kind == K_SPECIAL || i_cmd.kind == K_CONST_ADD) begin
                            r_state <= S_DIV_ADJ;
                        end else if (i_cmd.kind == K_ADV_PC) begin
                            r_state <= S_DIV_OPS;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIV_ADJ: begin
                    if (w_div_done) begin
                        r_delta <= w_rem;
                        r_state <= S_DIV_OPS;
                    end
                end
                S_DIV_OPS: begin
                    if (w_div_done) begin
                        r_op_idx <= w_rem;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_quo[ADDRESS_BITS-1:0] *
                               {{(ADDRESS_BITS-8){1'b0}}, i_cfg.min_len};
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_address <= r_address + r_prod;
                    if (r_cmd.kind == K_SPECIAL) begin
                        r_line <= r_line + {{56{i_cfg.ln_base[7]}}, i_cfg.ln_base}
                                  + {56'd0, r_delta};
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        case (r_cmd.kind) inside
                            K_END_SEQ: begin
                                r_address <= '0;
                                r_op_idx  <= 8'd0;
                                r_file    <= 64'd1;
                                r_line    <= 64'd1;
                                r_column  <= 64'd0;
                                r_is_stmt <= i_cfg.def_stmt;
                                r_bb      <= 1'b0;
                                r_pro     <= 1'b0;
                                r_epi     <= 1'b0;
                                r_isa     <= 64'd0;
                                r_disc    <= 64'd0;
                            end
                            K_COPY, K_SPECIAL: begin
                                r_bb   <= 1'b0;
                                r_pro  <= 1'b0;
                                r_epi  <= 1'b0;
                                r_disc <= 64'd0;
                            end
                            K_SET_ADDR: begin
                                r_address <= r_cmd.val_u[ADDRESS_BITS-1:0];
                                r_op_idx  <= 8'd0;
                            end
                            K_FIXED_ADV: begin
                                r_address <= r_address +
                                             ADDRESS_BITS'(r_cmd.val_u[15:0]);
                                r_op_idx  <= 8'd0;
                            end
                            K_SET_DISC:  r_disc    <= r_cmd.val_u;
                            K_ADV_LINE:  r_line    <= r_line + r_cmd.val_s;
                            K_SET_FILE:  r_file    <= r_cmd.val_u;
                            K_SET_COL:   r_column  <= r_cmd.val_u;
                            K_NEG_STMT:  r_is_stmt <= !r_is_stmt;
                            K_SET_BB:    r_bb      <= 1'b1;
                            K_PRO_END:   r_pro     <= 1'b1;
                            K_EPI_BEGIN: r_epi     <= 1'b1;
                            K_SET_ISA:   r_isa     <= r_cmd.val_u;
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat payload, loaded with the row as it stands before the update
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free && w_has_res) begin
            if (r_cmd.kind == K_ERROR) begin
                o_status            <= r_cmd.status;
                o_row_address       <= 64'd0;
                o_row_op_idx        <= 8'd0;
                o_row_file          <= 64'd0;
                o_row_line          <= 64'd0;
                o_row_column        <= 64'd0;
                o_row_flags         <= 5'd0;
                o_row_isa           <= 64'd0;
                o_row_discriminator <= 64'd0;
            end else begin
                o_status            <= ST_ROW;
                o_row_address       <= 64'(r_address);
                o_row_op_idx        <= r_op_idx;
                o_row_file          <= r_file;
                o_row_line          <= r_line;
                o_row_column        <= r_column;
                o_row_flags         <= {r_epi, r_pro, (r_cmd.kind == K_END_SEQ),
                                        r_bb, r_is_stmt};
                o_row_isa           <= r_isa;
                o_row_discriminator <= r_disc;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// File: hw/rtl/line_table_state_machine.sv
`timescale 1ns / 1ps
`default_nettype none
// Line-table row engine: runs one decoded line-number instruction per input beat.
// Input channel: i_valid / o_stall with opcode, extended opcode, extended length
// and the two decoded operands. Output channel: o_valid / i_stall carrying one
// result beat for copy, special opcodes, end of sequence and every error.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index, no wait;
// write only while the engine is idle.
// Register-only instructions go from the queue through the idle and emit states.
// The address advance runs one divide by the op count; constant-add and special
// opcodes first divide by the line range. Each divide runs at 4 bits per cycle,
// and the divides are followed by a multiply and an add.
// Items are executed one at a time, so the engine takes a new instruction only
// once it is through with the last one; a two-entry queue in front takes the
// next beats meanwhile and raises o_stall when full.
// Reset (synchronous, active low) restores the row registers and the
// configuration defaults and empties the queue and the output register.
// A stalled result beat holds; the engine waits with the next result until
// the output register is free.
module line_table_state_machine #(
    parameter int ADDRESS_BITS = ltsm_pkg::ADDR_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_opcode,
    input  wire  [7:0]  i_ext_opcode,
    input  wire  [7:0]  i_ext_length,
    input  wire  [63:0] i_operand_u,
    input  wire  [63:0] i_operand_s,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_row_address,
    output logic [7:0]  o_row_op_idx,
    output logic [63:0] o_row_file,
    output logic [63:0] o_row_line,
    output logic [63:0] o_row_column,
    output logic [4:0]  o_row_flags,
    output logic [63:0] o_row_isa,
    output logic [63:0] o_row_discriminator
);
    import ltsm_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_empty;
    logic w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len  <= 8'd1;
            r_cfg.max_ops  <= 8'd1;
            r_cfg.def_stmt <= 1'b1;
            r_cfg.ln_base  <= 8'hFB;
            r_cfg.line_rng <= 8'd14;
            r_cfg.first_sp <= 8'd13;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_LEN:   r_cfg.min_len  <= i_cfg_data;
                CFG_MAX_OPS:   r_cfg.max_ops  <= i_cfg_data;
                CFG_DEF_STMT:  r_cfg.def_stmt <= i_cfg_data[0];
                CFG_LINE_BASE: r_cfg.ln_base  <= i_cfg_data;
                CFG_LINE_RNG:  r_cfg.line_rng <= i_cfg_data;
                CFG_FIRST_SP:  r_cfg.first_sp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ltsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_ext_opcode (i_ext_opcode),
        .i_ext_length (i_ext_length),
        .i_operand_u  (i_operand_u),
        .i_operand_s  (i_operand_s),
        .i_pop        (w_pop),
        .o_empty      (w_empty),
        .o_cmd        (w_cmd)
    );

    ltsm_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_empty             (w_empty),
        .i_cmd               (w_cmd),
        .o_pop               (w_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_row_address       (o_row_address),
        .o_row_op_idx        (o_row_op_idx),
        .o_row_file          (o_row_file),
        .o_row_line          (o_row_line),
        .o_row_column        (o_row_column),
        .o_row_flags         (o_row_flags),
        .o_row_isa           (o_row_isa),
        .o_row_discriminator (o_row_discriminator)
    );

    // error beats carry no row
    a_err_zero_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_ROW |-> o_row_flags == 5'd0 &&
        o_row_address == 64'd0 && o_row_line == 64'd0 && o_row_file == 64'd0)
        else $error("error beat with nonzero row fields");

    // the end-of-sequence flag only shows on row beats
    a_end_seq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_row_flags[2] |-> o_status == ST_ROW)
        else $error("sequence end flag on an error beat");

    // the queue is never popped while empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: tb/line_table_state_machine_test.sv
`timescale 1ns / 1ps
module line_table_state_machine_test;
    import ltsm_pkg::*;

    // covers the engine plus a full queue of the slowest no-result instructions
    localparam int SETTLE_CYCLES = 200;
    localparam int STUCK_LIMIT   = 5000;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] address;
        logic [7:0]  opx;
        logic [63:0] file;
        logic [63:0] line;
        logic [63:0] column;
        logic [4:0]  flags;
        logic [63:0] isa;
        logic [63:0] disc;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_opcode = '0;
    logic [7:0]  i_ext_opcode = '0;
    logic [7:0]  i_ext_length = '0;
    logic [63:0] i_operand_u = '0;
    logic [63:0] i_operand_s = '0;
    logic        i_stall = 1'b0;
    wire         o_stall, o_valid;
    wire  [2:0]  o_status;
    wire  [63:0] o_row_address, o_row_file, o_row_line, o_row_column;
    wire  [63:0] o_row_isa, o_row_discriminator;
    wire  [7:0]  o_row_op_idx;
    wire  [4:0]  o_row_flags;

    line_table_state_machine dut (.*);

    always #4 i_clk = ~i_clk;

    // configuration mirror
    logic [7:0] min_len, max_ops, ln_base, line_rng, first_sp;
    logic       def_stmt;
    // row registers mirror
    logic [63:0] cur_addr, cur_file, cur_line, cur_col, cur_isa, cur_disc;
    logic [7:0]  cur_opx;
    logic        cur_stmt, cur_bb, cur_pro, cur_epi;

    t_row rows_due[$];
    int   errors = 0, items_sent = 0, rows_seen = 0, stuck = 0;
    int   send_idle = 0, recv_stall = 0;

    function automatic void init_rows();
        cur_addr = '0; cur_opx = '0; cur_file = 64'd1; cur_line = 64'd1;
        cur_col = '0; cur_stmt = def_stmt; cur_bb = 1'b0; cur_pro = 1'b0;
        cur_epi = 1'b0; cur_isa = '0; cur_disc = '0;
    endfunction

    function automatic t_row snap_row(logic end_seq);
        t_row r;
        r.status = ST_ROW; r.address = cur_addr; r.opx = cur_opx;
        r.file = cur_file; r.line = cur_line; r.column = cur_col;
        r.flags = {cur_epi, cur_pro, end_seq, cur_bb, cur_stmt};
        r.isa = cur_isa; r.disc = cur_disc;
        return r;
    endfunction

    function automatic void push_error(logic [2:0] code);
        t_row r;
        r = '0;
        r.status = code;
        rows_due.push_back(r);
    endfunction

    function automatic void emit_and_clear();
        rows_due.push_back(snap_row(1'b0));
        cur_bb = 1'b0; cur_pro = 1'b0; cur_epi = 1'b0; cur_disc = '0;
    endfunction

    function automatic void advance_ops(logic [63:0] adv);
        logic [63:0] m, q, sum;
        m = (max_ops == 0) ? 64'd1 : 64'(max_ops);
        q = adv / m;
        sum = 64'(cur_opx) + adv % m;
        q += sum / m;
        cur_opx = 8'(sum % m);
        cur_addr = cur_addr + 64'(min_len) * q;
    endfunction

    function automatic void apply_item(logic [7:0] op, logic [7:0] ext, logic [7:0] len,
                                       logic [63:0] u, logic [63:0] s);
        logic [7:0] rng, adj;
        rng = (line_rng == 0) ? 8'd1 : line_rng;
        if (op == OP_EXTENDED) begin
            case (ext)
                EXT_END_SEQ: begin
                    rows_due.push_back(snap_row(1'b1));
                    init_rows();
                end
                EXT_SET_ADDR: begin
                    if (len == SET_ADDR_LEN64) begin
                        cur_addr = u; cur_opx = '0;
                    end else if (len == SET_ADDR_LEN32) begin
                        cur_addr = {32'd0, u[31:0]}; cur_opx = '0;
                    end else begin
                        push_error(ST_BAD_ADDR);
                    end
                end
                EXT_DEF_FILE: push_error(ST_DEF_FILE);
                EXT_SET_DISC: cur_disc = u;
                default: push_error(ST_BAD_EXT);
            endcase
        end else if (op < first_sp) begin
            case (op)
                OP_COPY:      emit_and_clear();
                OP_ADV_PC:    advance_ops(u);
                OP_ADV_LINE:  cur_line = cur_line + s;
                OP_SET_FILE:  cur_file = u;
                OP_SET_COL:   cur_col = u;
                OP_NEG_STMT:  cur_stmt = ~cur_stmt;
                OP_SET_BB:    cur_bb = 1'b1;
                OP_CONST_ADD: advance_ops(64'((CONST_ADD_TOP - first_sp) / rng));
                OP_FIXED_ADV: begin
                    cur_addr = cur_addr + {48'd0, u[15:0]};
                    cur_opx = '0;
                end
                OP_PRO_END:   cur_pro = 1'b1;
                OP_EPI_BEGIN: cur_epi = 1'b1;
                OP_SET_ISA:   cur_isa = u;
                default:      push_error(ST_BAD_STD);
            endcase
        end else begin
            adj = op - first_sp;
            advance_ops(64'(adj / rng));
            cur_line = cur_line + {{56{ln_base[7]}}, ln_base} + 64'(adj % rng);
            emit_and_clear();
        end
    endfunction

    // receiver stall, changed on the falling edge
    always @(negedge i_clk)
        i_stall = ($urandom_range(99) < recv_stall);

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_row want;
        if (i_rst_n && o_valid && !i_stall) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat expected none actual status %0d",
                         $time, o_status);
            end else begin
                want = rows_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("address", want.address, o_row_address);
                check_field("op index", want.opx, o_row_op_idx);
                check_field("file", want.file, o_row_file);
                check_field("line", want.line, o_row_line);
                check_field("column", want.column, o_row_column);
                check_field("flags", want.flags, o_row_flags);
                check_field("isa", want.isa, o_row_isa);
                check_field("discriminator", want.disc, o_row_discriminator);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            stuck = 0;
        else if (++stuck >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // drive one beat from the falling edge; predict when it is taken
    task automatic send_item(logic [7:0] op, logic [7:0] ext, logic [7:0] len,
                             logic [63:0] u, logic [63:0] s);
        while ($urandom_range(99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode = op; i_ext_opcode = ext; i_ext_length = len;
        i_operand_u = u; i_operand_s = s; i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_item(op, ext, len, u, s);
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (rows_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MIN_LEN:   min_len = data;
            CFG_MAX_OPS:   max_ops = data;
            CFG_DEF_STMT:  def_stmt = data[0];
            CFG_LINE_BASE: ln_base = data;
            CFG_LINE_RNG:  line_rng = data;
            CFG_FIRST_SP:  first_sp = data;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] ml, logic [7:0] mo, logic ds, logic [7:0] lb,
                              logic [7:0] lr, logic [7:0] fs);
        wait_idle();
        write_reg(CFG_MIN_LEN, ml);
        write_reg(CFG_MAX_OPS, mo);
        write_reg(CFG_DEF_STMT, {7'd0, ds});
        write_reg(CFG_LINE_BASE, lb);
        write_reg(CFG_LINE_RNG, lr);
        write_reg(CFG_FIRST_SP, fs);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(3))
            0: return 64'($urandom_range(40));
            1: return 64'($urandom_range(2000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly sensible programs; a share of bad or odd instructions
    task automatic send_random();
        logic [7:0] op, ext, len;
        int pick;
        pick = $urandom_range(99);
        ext = 8'($urandom); len = 8'($urandom);
        if (pick < 8) begin
            op = OP_EXTENDED;
            ext = EXT_END_SEQ;
        end else if (pick < 18) begin
            op = OP_EXTENDED;
            if ($urandom_range(3) != 0) ext = 8'($urandom_range(1, 4));
            if ($urandom_range(3) != 0) len = $urandom_range(1) ? SET_ADDR_LEN64 : SET_ADDR_LEN32;
        end else if (pick < 60) begin
            op = 8'($urandom_range(1, 12));
        end else if (pick < 66) begin
            op = 8'($urandom);
        end else begin
            op = 8'($urandom_range(first_sp, 255));
        end
        send_item(op, ext, len, rand_word(), rand_word());
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        send_item(OP_EXTENDED, EXT_SET_ADDR, SET_ADDR_LEN64, ones, 0);
        send_item(OP_COPY, 0, 0, 0, 0);
        send_item(OP_ADV_PC, 0, 0, ones, 0);
        send_item(8'd13, 0, 0, 0, 0);
        send_item(8'd255, 0, 0, 0, 0);
        send_item(OP_ADV_LINE, 0, 0, 0, 64'h8000_0000_0000_0000);
        send_item(OP_ADV_LINE, 0, 0, 0, 64'h7fff_ffff_ffff_ffff);
        send_item(OP_SET_FILE, 0, 0, ones, 0);
        send_item(OP_SET_COL, 0, 0, ones, 0);
        send_item(OP_NEG_STMT, 0, 0, 0, 0);
        send_item(OP_SET_BB, 0, 0, 0, 0);
        send_item(OP_CONST_ADD, 0, 0, 0, 0);
        send_item(OP_FIXED_ADV, 0, 0, ones, 0);
        send_item(OP_PRO_END, 0, 0, 0, 0);
        send_item(OP_EPI_BEGIN, 0, 0, 0, 0);
        send_item(OP_SET_ISA, 0, 0, ones, 0);
        send_item(OP_EXTENDED, EXT_SET_DISC, 0, ones, 0);
        send_item(OP_COPY, 0, 0, 0, 0);
        send_item(OP_EXTENDED, EXT_SET_ADDR, SET_ADDR_LEN32, ones, 0);
        send_item(OP_EXTENDED, EXT_SET_ADDR, 8'd0, 0, 0);
        send_item(OP_EXTENDED, EXT_DEF_FILE, 0, 0, 0);
        send_item(OP_EXTENDED, 8'd0, 0, 0, 0);
        send_item(OP_EXTENDED, 8'd255, 8'd255, ones, ones);
        send_item(OP_EXTENDED, EXT_END_SEQ, 0, 0, 0);
        send_item(OP_COPY, 0, 0, 0, 0);
    endtask

    task automatic test_config_sweep();
        send_idle = 20; recv_stall = 20;
        set_config(8'd0, 8'd255, 1'b0, 8'h80, 8'd255, 8'd255);
        repeat (40) send_random();
        set_config(8'd255, 8'd0, 1'b1, 8'h7f, 8'd0, 8'd1);
        repeat (40) send_random();
        set_config(8'd4, 8'd3, 1'b0, 8'hfd, 8'd12, 8'd10);
        repeat (40) send_random();
        set_config(8'd255, 8'd255, 1'b1, 8'h00, 8'd1, 8'd40);
        repeat (40) send_random();
        set_config(8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom_range(1, 255)));
        repeat (40) send_random();
        set_config(8'd1, 8'd1, 1'b1, 8'hfb, 8'd14, 8'd13);
        repeat (40) send_random();
    endtask

    task automatic test_flow_control();
        send_idle = 0;  recv_stall = 0;  repeat (60) send_random();
        send_idle = 76; recv_stall = 0;  repeat (60) send_random();
        // hold off until the engine has drained
        wait_idle();
        send_idle = 0;  recv_stall = 76; repeat (60) send_random();
        send_idle = 14; recv_stall = 14; repeat (60) send_random();
        send_idle = 0;  recv_stall = 0;
    endtask

    initial begin
        min_len = 8'd1; max_ops = 8'd1; def_stmt = 1'b1;
        ln_base = 8'hfb; line_rng = 8'd14; first_sp = 8'd13;
        init_rows();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_sweep();
        test_flow_control();
        wait_idle();
        $display("Ran %0d instructions over 7 register settings and 4 flow-control phases;",
                 items_sent);
        $display("checked %0d result beats, %0d errors.", rows_seen, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
